FILE: rtl/smx_pkg.sv
`timescale 1ns / 1ps
package smx_pkg;

	localparam int STACK_DEPTH = 256;
	localparam int MEM_WORDS   = 1024;
	localparam int PROG_WORDS  = 1024;

	localparam int SP_AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int SD_W  = $clog2(STACK_DEPTH + 1);
	localparam int MEM_AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
	localparam int PC_W  = 11;
	localparam int ST_W  = 4;

	localparam logic [4:0] OP_NOP      = 5'd0;
	localparam logic [4:0] OP_STOP     = 5'd1;
	localparam logic [4:0] OP_LOAD     = 5'd2;
	localparam logic [4:0] OP_STORE    = 5'd3;
	localparam logic [4:0] OP_BLOAD    = 5'd4;
	localparam logic [4:0] OP_BSTORE   = 5'd5;
	localparam logic [4:0] OP_PUSH     = 5'd6;
	localparam logic [4:0] OP_POP      = 5'd7;
	localparam logic [4:0] OP_DUP      = 5'd8;
	localparam logic [4:0] OP_INVERT   = 5'd9;
	localparam logic [4:0] OP_ADD      = 5'd10;
	localparam logic [4:0] OP_SUB      = 5'd11;
	localparam logic [4:0] OP_MULT     = 5'd12;
	localparam logic [4:0] OP_DIV      = 5'd13;
	localparam logic [4:0] OP_COMPARE  = 5'd14;
	localparam logic [4:0] OP_JUMP     = 5'd15;
	localparam logic [4:0] OP_JUMP_YES = 5'd16;
	localparam logic [4:0] OP_JUMP_NO  = 5'd17;
	localparam logic [4:0] OP_INPUT    = 5'd18;
	localparam logic [4:0] OP_PRINT    = 5'd19;

	localparam logic [2:0] REL_EQ = 3'd0;
	localparam logic [2:0] REL_NE = 3'd1;
	localparam logic [2:0] REL_LT = 3'd2;
	localparam logic [2:0] REL_GT = 3'd3;
	localparam logic [2:0] REL_LE = 3'd4;
	localparam logic [2:0] REL_GE = 3'd5;

	localparam logic [ST_W-1:0] ST_RUN       = 4'd0;
	localparam logic [ST_W-1:0] ST_STOP      = 4'd1;
	localparam logic [ST_W-1:0] ST_OFF_END   = 4'd2;
	localparam logic [ST_W-1:0] ST_BAD_DATA  = 4'd3;
	localparam logic [ST_W-1:0] ST_BAD_CODE  = 4'd4;
	localparam logic [ST_W-1:0] ST_BAD_REL   = 4'd5;
	localparam logic [ST_W-1:0] ST_OVERFLOW  = 4'd6;
	localparam logic [ST_W-1:0] ST_EMPTY     = 4'd7;
	localparam logic [ST_W-1:0] ST_DIV_ZERO  = 4'd8;
	localparam logic [ST_W-1:0] ST_BAD_INPUT = 4'd9;
	localparam logic [ST_W-1:0] ST_UNKNOWN   = 4'd10;

	typedef struct packed {
		logic [4:0]         opcode;
		logic signed [31:0] argument;
		logic signed [31:0] input_value;
		logic               input_ok;
	} smx_in_t;

	typedef struct packed {
		logic [PC_W-1:0]    next_pc;
		logic               print_valid;
		logic signed [31:0] print_value;
		logic [ST_W-1:0]    status;
	} smx_out_t;

	typedef struct packed {
		logic clr;
		logic latch;
		logic rd1;
		logic rd2;
		logic rd3;
		logic exec;
		logic div_wait;
		logic wb;
	} smx_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic div_go;
		logic div_done;
		logic out_free;
	} smx_sts_t;

endpackage

FILE: rtl/smx_div.sv
`timescale 1ns / 1ps
module smx_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);
	import smx_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic        neg_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] den_q;
	logic [32:0] shifted;
	logic [32:0] diff;
	logic        ge;

	assign shifted = {rem_q, quo_q[31]};
	assign diff    = shifted - {1'b0, den_q};
	assign ge      = !diff[32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// restoring division on magnitudes, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[31] ? (32'd0 - dividend) : dividend;
			den_q <= divisor[31] ? (32'd0 - divisor) : divisor;
			neg_q <= dividend[31] ^ divisor[31];
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : shifted[31:0];
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (32'd0 - quo_q) : quo_q;
endmodule

FILE: rtl/smx_ctrl.sv
`timescale 1ns / 1ps
module smx_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  smx_pkg::smx_sts_t sts,
	output smx_pkg::smx_cmd_t cmd
);
	import smx_pkg::*;

	typedef enum logic [7:0] {
		S_CLEAR = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_RD1   = 8'b0000_0100,
		S_RD2   = 8'b0000_1000,
		S_RD3   = 8'b0001_0000,
		S_EXEC  = 8'b0010_0000,
		S_DIV   = 8'b0100_0000,
		S_WB    = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_RD1;
				end
			end
			S_RD1: begin
				cmd.rd1 = 1'b1;
				state_d = S_RD2;
			end
			S_RD2: begin
				cmd.rd2 = 1'b1;
				state_d = S_RD3;
			end
			S_RD3: begin
				cmd.rd3 = 1'b1;
				state_d = S_EXEC;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.div_go ? S_DIV : S_WB;
			end
			S_DIV: begin
				cmd.div_wait = 1'b1;
				if (sts.div_done) state_d = S_WB;
			end
			S_WB: begin
				// hold the result until the output register frees up
				if (sts.out_free) begin
					cmd.wb  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	assign in_ready = (state_q == S_IDLE);
endmodule

FILE: rtl/smx_dp.sv
`timescale 1ns / 1ps
module smx_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  smx_pkg::smx_cmd_t  cmd,
	output smx_pkg::smx_sts_t  sts,
	input  smx_pkg::smx_in_t   in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output smx_pkg::smx_out_t  out_data
);
	import smx_pkg::*;

	logic [31:0] stk_mem [STACK_DEPTH];
	logic [31:0] dat_mem [MEM_WORDS];

	logic [4:0]        op_q;
	logic [31:0]       arg_q;
	logic [31:0]       inval_q;
	logic              ok_q;
	logic [SD_W-1:0]   depth_q;
	logic [PC_W-1:0]   pc_q;
	logic              halt_q;
	logic [ST_W-1:0]   hcode_q;
	logic [MEM_AW-1:0] clr_cnt_q;

	logic [31:0] stk_rd_q, dat_rd_q;
	logic [31:0] x_q, y_q, lm_q, bm_q;

	logic [SP_AW-1:0]  stk_ra;
	logic [MEM_AW-1:0] dat_ra;
	logic [31:0]       bsum_rd;

	// plan of the current instruction, applied at write-back
	logic [ST_W-1:0]   pl_st_q;
	logic [PC_W-1:0]   pl_next_q;
	logic [SD_W-1:0]   pl_d_q;
	logic              pl_swe_q;
	logic [SP_AW-1:0]  pl_swa_q;
	logic [31:0]       pl_swd_q;
	logic              pl_mwe_q;
	logic [MEM_AW-1:0] pl_mwa_q;
	logic [31:0]       pl_mwd_q;
	logic              pl_pv_q;

	logic [ST_W-1:0]   st;
	logic [PC_W-1:0]   nxt;
	logic [SD_W-1:0]   nd;
	logic              swe, mwe, pv, div_go;
	logic [SP_AW-1:0]  swa;
	logic [31:0]       swd;
	logic [MEM_AW-1:0] mwa;
	logic [31:0]       mwd;

	logic [SP_AW-1:0]  top_a, sec_a, new_a;
	logic              empty1, empty2, full, arg_bad_mem, arg_bad_prog, bsum_bad;
	logic [31:0]       bsum;
	logic              rel_res;
	logic [31:0]       prod;

	logic        div_done;
	logic [31:0] div_q;

	logic        out_valid_q;
	smx_out_t    out_q;

	assign top_a = SP_AW'(depth_q - SD_W'(1));
	assign sec_a = SP_AW'(depth_q - SD_W'(2));
	assign new_a = SP_AW'(depth_q);
	assign bsum_rd = arg_q + stk_rd_q;

	always_comb begin
		stk_ra = top_a;
		dat_ra = arg_q[MEM_AW-1:0];
		if (cmd.rd2) begin
			stk_ra = sec_a;
			dat_ra = bsum_rd[MEM_AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd1 || cmd.rd2) begin
			stk_rd_q <= stk_mem[stk_ra];
			dat_rd_q <= dat_mem[dat_ra];
		end
		if (cmd.wb && pl_swe_q) stk_mem[pl_swa_q] <= pl_swd_q;
		if (cmd.clr) dat_mem[clr_cnt_q] <= '0;
		else if (cmd.wb && pl_mwe_q) dat_mem[pl_mwa_q] <= pl_mwd_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q    <= in_data.opcode;
			arg_q   <= in_data.argument;
			inval_q <= in_data.input_value;
			ok_q    <= in_data.input_ok;
		end
		if (cmd.rd2) begin
			y_q  <= stk_rd_q;
			lm_q <= dat_rd_q;
		end
		if (cmd.rd3) begin
			x_q  <= stk_rd_q;
			bm_q <= dat_rd_q;
		end
	end

	assign empty1       = (depth_q == '0);
	assign empty2       = (depth_q < SD_W'(2));
	assign full         = (depth_q == SD_W'(STACK_DEPTH));
	assign arg_bad_mem  = (arg_q >= 32'(MEM_WORDS));
	assign arg_bad_prog = (arg_q >= 32'(PROG_WORDS));
	assign bsum         = arg_q + y_q;
	assign bsum_bad     = (bsum >= 32'(MEM_WORDS));
	assign prod         = x_q * y_q;

	always_comb begin
		unique case (arg_q[2:0])
			REL_EQ:  rel_res = (x_q == y_q);
			REL_NE:  rel_res = (x_q != y_q);
			REL_LT:  rel_res = ($signed(x_q) < $signed(y_q));
			REL_GT:  rel_res = ($signed(x_q) > $signed(y_q));
			REL_LE:  rel_res = ($signed(x_q) <= $signed(y_q));
			REL_GE:  rel_res = ($signed(x_q) >= $signed(y_q));
			default: rel_res = 1'b0;
		endcase
	end

	always_comb begin
		st     = ST_RUN;
		nxt    = pc_q + PC_W'(1);
		nd     = depth_q;
		swe    = 1'b0;
		swa    = top_a;
		swd    = y_q;
		mwe    = 1'b0;
		mwa    = arg_q[MEM_AW-1:0];
		mwd    = y_q;
		pv     = 1'b0;
		div_go = 1'b0;
		case (op_q) inside
			OP_NOP: ;
			OP_STOP: st = ST_STOP;
			OP_LOAD: begin
				if (arg_bad_mem) st = ST_BAD_DATA;
				else if (full) st = ST_OVERFLOW;
				else begin
					swe = 1'b1; swa = new_a; swd = lm_q; nd = depth_q + SD_W'(1);
				end
			end
			OP_STORE: begin
				if (empty1) st = ST_EMPTY;
				else if (arg_bad_mem) st = ST_BAD_DATA;
				else begin
					mwe = 1'b1; nd = depth_q - SD_W'(1);
				end
			end
			OP_BLOAD: begin
				if (empty1) st = ST_EMPTY;
				else if (bsum_bad) st = ST_BAD_DATA;
				else begin
					swe = 1'b1; swd = bm_q;
				end
			end
			OP_BSTORE: begin
				if (empty2) st = ST_EMPTY;
				else if (bsum_bad) st = ST_BAD_DATA;
				else begin
					mwe = 1'b1; mwa = bsum[MEM_AW-1:0]; mwd = x_q;
					nd = depth_q - SD_W'(2);
				end
			end
			OP_PUSH: begin
				if (full) st = ST_OVERFLOW;
				else begin
					swe = 1'b1; swa = new_a; swd = arg_q; nd = depth_q + SD_W'(1);
				end
			end
			OP_POP: begin
				if (empty1) st = ST_EMPTY;
				else nd = depth_q - SD_W'(1);
			end
			OP_DUP: begin
				if (empty1) st = ST_EMPTY;
				else if (full) st = ST_OVERFLOW;
				else begin
					swe = 1'b1; swa = new_a; nd = depth_q + SD_W'(1);
				end
			end
			OP_INVERT: begin
				if (empty1) st = ST_EMPTY;
				else begin
					swe = 1'b1; swd = 32'd0 - y_q;
				end
			end
			OP_ADD, OP_SUB, OP_MULT: begin
				if (empty2) st = ST_EMPTY;
				else begin
					swe = 1'b1; swa = sec_a; nd = depth_q - SD_W'(1);
					if (op_q == OP_ADD) swd = x_q + y_q;
					else if (op_q == OP_SUB) swd = x_q - y_q;
					else swd = prod;
				end
			end
			OP_DIV: begin
				if (empty1) st = ST_EMPTY;
				else if (y_q == '0) st = ST_DIV_ZERO;
				else if (empty2) st = ST_EMPTY;
				else begin
					swe = 1'b1; swa = sec_a; nd = depth_q - SD_W'(1);
					div_go = !halt_q;
				end
			end
			OP_COMPARE: begin
				if (empty1) st = ST_EMPTY;
				else if (arg_q > 32'd5) st = ST_BAD_REL;
				else if (empty2) st = ST_EMPTY;
				else begin
					swe = 1'b1; swa = sec_a; swd = {31'd0, rel_res};
					nd = depth_q - SD_W'(1);
				end
			end
			OP_JUMP: begin
				if (arg_bad_prog) st = ST_BAD_CODE;
				else nxt = PC_W'(arg_q);
			end
			OP_JUMP_YES, OP_JUMP_NO: begin
				if (arg_bad_prog) st = ST_BAD_CODE;
				else if (empty1) st = ST_EMPTY;
				else begin
					nd = depth_q - SD_W'(1);
					if ((op_q == OP_JUMP_YES) == (y_q != '0)) nxt = PC_W'(arg_q);
				end
			end
			OP_INPUT: begin
				if (!ok_q) st = ST_BAD_INPUT;
				else if (full) st = ST_OVERFLOW;
				else begin
					swe = 1'b1; swa = new_a; swd = inval_q; nd = depth_q + SD_W'(1);
				end
			end
			OP_PRINT: begin
				if (empty1) st = ST_EMPTY;
				else begin
					pv = 1'b1; nd = depth_q - SD_W'(1);
				end
			end
			default: st = ST_UNKNOWN;
		endcase

		if (halt_q) begin
			st = hcode_q; nxt = pc_q; nd = depth_q;
			swe = 1'b0; mwe = 1'b0; pv = 1'b0; div_go = 1'b0;
		end else if (st >= ST_BAD_DATA) begin
			// a faulting instruction leaves pc, stack depth, stack and memory alone and prints nothing
			nxt = pc_q; nd = depth_q;
			swe = 1'b0; mwe = 1'b0; pv = 1'b0; div_go = 1'b0;
		end else if (st == ST_RUN && nxt >= PC_W'(PROG_WORDS)) begin
			st = ST_OFF_END;
		end else if (st == ST_STOP) begin
			nxt = pc_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			pl_st_q   <= st;
			pl_next_q <= nxt;
			pl_d_q    <= nd;
			pl_swe_q  <= swe;
			pl_swa_q  <= swa;
			pl_swd_q  <= swd;
			pl_mwe_q  <= mwe;
			pl_mwa_q  <= mwa;
			pl_mwd_q  <= mwd;
			pl_pv_q   <= pv;
		end else if (cmd.div_wait && div_done) begin
			pl_swd_q <= div_q;
		end
		if (cmd.wb) out_q <= '{next_pc: pl_next_q, print_valid: pl_pv_q,
			print_value: pl_pv_q ? y_q : 32'd0, status: pl_st_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q     <= '0;
			pc_q        <= '0;
			halt_q      <= 1'b0;
			hcode_q     <= ST_RUN;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr) clr_cnt_q <= clr_cnt_q + MEM_AW'(1);
			if (cmd.wb) begin
				depth_q <= pl_d_q;
				pc_q    <= pl_next_q;
				if (pl_st_q != ST_RUN) begin
					halt_q  <= 1'b1;
					hcode_q <= pl_st_q;
				end
			end
			if (cmd.wb) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	smx_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.exec && div_go),
		.dividend (x_q),
		.divisor  (y_q),
		.done     (div_done),
		.quotient (div_q)
	);

	assign sts.clr_done = (clr_cnt_q == MEM_AW'(MEM_WORDS - 1));
	assign sts.div_go   = div_go;
	assign sts.div_done = div_done;
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule

FILE: rtl/stack_machine_executor_top.sv
`timescale 1ns / 1ps
// Stack machine executor: runs one instruction per request.
// Input channel (in_valid/in_ready/in_data): opcode, argument, input value
// and its ok flag of the instruction found at the last reported next_pc.
// Output channel (out_valid/out_ready/out_data): one result per request with
// next_pc, the PRINT value if any, and the status code.
// Each accepted request passes through states RD1, RD2, RD3 and EXEC to WB;
// DIV adds the DIV wait state for its bit-serial divider. One request is in
// flight at a time, and each one steps through the sequence of stack and
// data memory reads through single read ports.
// Reset: stack, program counter and halt flag clear at once; the data
// memory is then zeroed one word a cycle, all 1024 words, with in_ready low.
// A stalled receiver holds the result in the output register; the next
// request is still accepted and executed, and waits at write-back until the
// register frees. After any nonzero status the block is halted and every
// further request returns the stored pc and status until reset.
module stack_machine_executor_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  smx_pkg::smx_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output smx_pkg::smx_out_t out_data
);
	import smx_pkg::*;

	smx_cmd_t cmd;
	smx_sts_t sts;

	smx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	smx_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);
endmodule
